// ===== design/sexpr_tok_pkg.sv =====
// Shared types and constants for the s-expression tokenizer.
package sexpr_tok_pkg;

    localparam int MAX_STRING_DEF = 256;
    localparam int MAX_SYMBOL_DEF = 128;

    // Most results one character can cause, and the result queue depth.
    localparam int MAX_RES = 3;
    localparam int Q_DEPTH = 4;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_COMMENT = 3'd1,
        MODE_INT     = 3'd2,
        MODE_MINUS   = 3'd3,
        MODE_SYM     = 3'd4,
        MODE_STR     = 3'd5
    } lex_mode_t;

    typedef enum logic [3:0] {
        K_OPEN   = 4'd0,
        K_CLOSE  = 4'd1,
        K_QUOTE  = 4'd2,
        K_INT    = 4'd3,
        K_SYMCH  = 4'd4,
        K_SYMEND = 4'd5,
        K_STRCH  = 4'd6,
        K_STREND = 4'd7,
        K_EOF    = 4'd8,
        K_LONG   = 4'd9,
        K_UNTERM = 4'd10
    } tok_kind_t;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQUOT = 8'h22;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    typedef struct packed {
        tok_kind_t          kind;
        logic [7:0]         char_out;
        logic signed [31:0] int_value;
        logic signed [15:0] nest_depth;
        logic               last;
    } tok_res_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    // ~!@#$%^&*_-+\:,.<>|{}[]?=/
    function automatic logic is_punct(input logic [7:0] c);
        logic hit;
        case (c)
            8'h7E, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
            8'h5F, 8'h2D, 8'h2B, 8'h5C, 8'h3A, 8'h2C, 8'h2E, 8'h3C, 8'h3E,
            8'h7C, 8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h2F: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic tok_res_t mk_res(input tok_kind_t k, input logic [7:0] c,
                                        input logic [31:0] v, input logic [15:0] d);
        tok_res_t r;
        r.kind       = k;
        r.char_out   = c;
        r.int_value  = v;
        r.nest_depth = d;
        r.last       = 1'b0;
        return r;
    endfunction

endpackage

// ===== design/sexpr_tok_in_if.sv =====
// Character channel of the tokenizer: one source byte or end-of-input per beat.
interface sexpr_tok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_input;

    modport source (output valid, output char_in, output end_of_input, input ready);
    modport sink   (input valid, input char_in, input end_of_input, output ready);
endinterface

// ===== design/sexpr_tok_out_if.sv =====
// Token channel of the tokenizer: one result per beat.
interface sexpr_tok_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         kind;
    logic [7:0]         char_out;
    logic signed [31:0] int_value;
    logic signed [15:0] nest_depth;
    logic               last;

    modport source (output valid, output kind, output char_out, output int_value,
                    output nest_depth, output last, input ready);
    modport sink   (input valid, input kind, input char_out, input int_value,
                    input nest_depth, input last, output ready);
endinterface

// ===== design/sexpr_tokenizer.sv =====
// Streaming s-expression lexer: character beats in, token beats out.
//
// char_chan takes one source byte per beat, or an end-of-input mark. tok_chan
// gives one token result per beat; last marks the final result of one byte.
// A byte is held in an input register, lexed against the lexer state, and its
// zero to three results go into a four-entry result queue that feeds tok_chan.
// Throughput: one byte per cycle while each byte yields at most one result and
// tok_chan.ready stays high; bytes with two or three results can hold later
// bytes back, since the queue drains one result per beat.
// The input register advances only when the queue has room for three results,
// so a stalled receiver soon leaves the queue short of that room, and
// char_chan.ready then goes low; nothing is dropped. Reset clears the lexer
// state, the input valid flag and the queue count and pointer; no token is
// offered until a byte arrives. A too-long symbol or string halts the lexer:
// later bytes are still accepted but yield nothing until reset.
module sexpr_tokenizer
    import sexpr_tok_pkg::*;
#(
    parameter int MAX_STRING = MAX_STRING_DEF,
    parameter int MAX_SYMBOL = MAX_SYMBOL_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    sexpr_tok_in_if.sink     char_chan,
    sexpr_tok_out_if.source  tok_chan
);

    localparam int MaxLen = (MAX_STRING > MAX_SYMBOL) ? MAX_STRING : MAX_SYMBOL;
    localparam int LenW   = $clog2(MaxLen + 1);
    localparam int PtrW   = $clog2(Q_DEPTH);
    localparam int CntW   = $clog2(Q_DEPTH + 1);
    localparam int ResW   = $clog2(MAX_RES + 1);

    // input register
    logic       in_vld_reg;
    logic [7:0] in_char_reg;
    logic       in_eoi_reg;

    // lexer state
    lex_mode_t   mode_reg, mode_next;
    logic [31:0] acc_reg, acc_next;
    logic        neg_reg, neg_next;
    logic [LenW-1:0] len_reg, len_next;
    logic [15:0] depth_reg, depth_next;
    logic        halt_reg, halt_next;

    // result queue
    tok_res_t        q_reg [Q_DEPTH];
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] cnt_reg;
    logic [CntW-1:0] cnt_after;
    logic [PtrW-1:0] wr_ptr;

    tok_res_t        res_arr [MAX_RES];
    logic [ResW-1:0] n_res;
    logic            add_sym;
    logic            redo;
    logic [31:0]     int_val;
    logic [31:0]     digit_val;
    logic            pop;
    logic            consume;

    assign pop       = (cnt_reg != '0) && tok_chan.ready;
    assign cnt_after = cnt_reg - CntW'(pop);
    assign consume   = in_vld_reg &&
                       ((CntW + 1)'(cnt_after) + (CntW + 1)'(MAX_RES) <= (CntW + 1)'(Q_DEPTH));
    assign wr_ptr    = rd_ptr_reg + cnt_reg[PtrW-1:0];

    assign char_chan.ready = !in_vld_reg || consume;

    assign tok_chan.valid      = (cnt_reg != '0);
    assign tok_chan.kind       = q_reg[rd_ptr_reg].kind;
    assign tok_chan.char_out   = q_reg[rd_ptr_reg].char_out;
    assign tok_chan.int_value  = q_reg[rd_ptr_reg].int_value;
    assign tok_chan.nest_depth = q_reg[rd_ptr_reg].nest_depth;
    assign tok_chan.last       = q_reg[rd_ptr_reg].last;

    assign int_val   = neg_reg ? (32'd0 - acc_reg) : acc_reg;
    assign digit_val = {28'd0, in_char_reg[3:0]};

    // Lex one byte: next state and the results it causes.
    always_comb
    begin
        mode_next  = mode_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        len_next   = len_reg;
        depth_next = depth_reg;
        halt_next  = halt_reg;
        n_res      = '0;
        add_sym    = 1'b0;
        redo       = 1'b0;
        for (int i = 0; i < MAX_RES; i++)
        begin
            res_arr[i] = '0;
        end

        if (consume && !halt_reg)
        begin
            case (mode_reg)
                MODE_COMMENT:
                begin
                    if (in_eoi_reg)
                    begin
                        mode_next = MODE_IDLE;
                        res_arr[n_res] = mk_res(K_EOF, 8'd0, 32'd0, depth_next);
                        n_res = n_res + 1'b1;
                    end
                    else if (in_char_reg == CH_LF)
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_INT:
                begin
                    if (in_eoi_reg)
                    begin
                        mode_next = MODE_IDLE;
                        res_arr[n_res] = mk_res(K_INT, 8'd0, int_val, depth_next);
                        n_res = n_res + 1'b1;
                        res_arr[n_res] = mk_res(K_EOF, 8'd0, 32'd0, depth_next);
                        n_res = n_res + 1'b1;
                    end
                    else if (is_digit(in_char_reg))
                    begin
                        acc_next = (acc_reg << 3) + (acc_reg << 1) + digit_val;
                    end
                    else
                    begin
                        mode_next = MODE_IDLE;
                        res_arr[n_res] = mk_res(K_INT, 8'd0, int_val, depth_next);
                        n_res = n_res + 1'b1;
                        redo = 1'b1;
                    end
                end
                MODE_MINUS:
                begin
                    if (!in_eoi_reg && is_digit(in_char_reg))
                    begin
                        mode_next = MODE_INT;
                        acc_next  = digit_val;
                        neg_next  = 1'b1;
                    end
                    else
                    begin
                        len_next = LenW'(1);
                        res_arr[n_res] = mk_res(K_SYMCH, CH_MINUS, 32'd0, depth_next);
                        n_res = n_res + 1'b1;
                        if (in_eoi_reg)
                        begin
                            mode_next = MODE_IDLE;
                            res_arr[n_res] = mk_res(K_SYMEND, 8'd0, 32'd0, depth_next);
                            n_res = n_res + 1'b1;
                            res_arr[n_res] = mk_res(K_EOF, 8'd0, 32'd0, depth_next);
                            n_res = n_res + 1'b1;
                        end
                        else if (is_alpha(in_char_reg) || is_digit(in_char_reg) ||
                                 is_punct(in_char_reg))
                        begin
                            mode_next = MODE_SYM;
                            add_sym   = 1'b1;
                        end
                        else
                        begin
                            mode_next = MODE_IDLE;
                            res_arr[n_res] = mk_res(K_SYMEND, 8'd0, 32'd0, depth_next);
                            n_res = n_res + 1'b1;
                            redo = 1'b1;
                        end
                    end
                end
                MODE_SYM:
                begin
                    if (in_eoi_reg)
                    begin
                        mode_next = MODE_IDLE;
                        res_arr[n_res] = mk_res(K_SYMEND, 8'd0, 32'd0, depth_next);
                        n_res = n_res + 1'b1;
                        res_arr[n_res] = mk_res(K_EOF, 8'd0, 32'd0, depth_next);
                        n_res = n_res + 1'b1;
                    end
                    else if (is_alpha(in_char_reg) || is_digit(in_char_reg) ||
                             is_punct(in_char_reg))
                    begin
                        add_sym = 1'b1;
                    end
                    else
                    begin
                        mode_next = MODE_IDLE;
                        res_arr[n_res] = mk_res(K_SYMEND, 8'd0, 32'd0, depth_next);
                        n_res = n_res + 1'b1;
                        redo = 1'b1;
                    end
                end
                MODE_STR:
                begin
                    if (in_eoi_reg)
                    begin
                        mode_next = MODE_IDLE;
                        res_arr[n_res] = mk_res(K_UNTERM, 8'd0, 32'd0, depth_next);
                        n_res = n_res + 1'b1;
                    end
                    else if (in_char_reg == CH_DQUOT)
                    begin
                        mode_next = MODE_IDLE;
                        res_arr[n_res] = mk_res(K_STREND, 8'd0, 32'd0, depth_next);
                        n_res = n_res + 1'b1;
                    end
                    else if (len_reg >= LenW'(MAX_STRING))
                    begin
                        mode_next = MODE_IDLE;
                        halt_next = 1'b1;
                        res_arr[n_res] = mk_res(K_LONG, 8'd0, 32'd0, depth_next);
                        n_res = n_res + 1'b1;
                    end
                    else
                    begin
                        len_next = len_reg + 1'b1;
                        res_arr[n_res] = mk_res(K_STRCH, in_char_reg, 32'd0, depth_next);
                        n_res = n_res + 1'b1;
                    end
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                    if (in_eoi_reg)
                    begin
                        res_arr[n_res] = mk_res(K_EOF, 8'd0, 32'd0, depth_next);
                        n_res = n_res + 1'b1;
                    end
                    else
                    begin
                        redo = 1'b1;
                    end
                end
            endcase

            // append a byte to the symbol, or stop on overflow
            if (add_sym)
            begin
                if (len_next >= LenW'(MAX_SYMBOL))
                begin
                    mode_next = MODE_IDLE;
                    halt_next = 1'b1;
                    res_arr[n_res] = mk_res(K_LONG, 8'd0, 32'd0, depth_next);
                    n_res = n_res + 1'b1;
                end
                else
                begin
                    len_next = len_next + 1'b1;
                    res_arr[n_res] = mk_res(K_SYMCH, in_char_reg, 32'd0, depth_next);
                    n_res = n_res + 1'b1;
                end
            end

            // handle the byte as fresh input in the idle mode
            if (redo)
            begin
                if (in_char_reg == CH_SPACE || in_char_reg == CH_TAB ||
                    in_char_reg == CH_LF || in_char_reg == CH_CR)
                begin
                    mode_next = MODE_IDLE;
                end
                else if (in_char_reg == CH_SEMI)
                begin
                    mode_next = MODE_COMMENT;
                end
                else if (in_char_reg == CH_DQUOT)
                begin
                    mode_next = MODE_STR;
                    len_next  = '0;
                end
                else if (in_char_reg == CH_QUOTE)
                begin
                    res_arr[n_res] = mk_res(K_QUOTE, 8'd0, 32'd0, depth_next);
                    n_res = n_res + 1'b1;
                end
                else if (in_char_reg == CH_OPEN)
                begin
                    depth_next = depth_next + 16'd1;
                    res_arr[n_res] = mk_res(K_OPEN, 8'd0, 32'd0, depth_next);
                    n_res = n_res + 1'b1;
                end
                else if (in_char_reg == CH_CLOSE)
                begin
                    depth_next = depth_next - 16'd1;
                    res_arr[n_res] = mk_res(K_CLOSE, 8'd0, 32'd0, depth_next);
                    n_res = n_res + 1'b1;
                end
                else if (is_digit(in_char_reg))
                begin
                    mode_next = MODE_INT;
                    acc_next  = digit_val;
                    neg_next  = 1'b0;
                end
                else if (in_char_reg == CH_MINUS)
                begin
                    mode_next = MODE_MINUS;
                end
                else if (is_alpha(in_char_reg) || is_punct(in_char_reg))
                begin
                    mode_next = MODE_SYM;
                    len_next  = LenW'(1);
                    res_arr[n_res] = mk_res(K_SYMCH, in_char_reg, 32'd0, depth_next);
                    n_res = n_res + 1'b1;
                end
            end
        end

        for (int i = 0; i < MAX_RES; i++)
        begin
            res_arr[i].last = (ResW'(i + 1) == n_res);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            mode_reg   <= MODE_IDLE;
            acc_reg    <= '0;
            neg_reg    <= 1'b0;
            len_reg    <= '0;
            depth_reg  <= '0;
            halt_reg   <= 1'b0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (char_chan.valid && char_chan.ready)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (consume)
            begin
                in_vld_reg <= 1'b0;
            end
            mode_reg   <= mode_next;
            acc_reg    <= acc_next;
            neg_reg    <= neg_next;
            len_reg    <= len_next;
            depth_reg  <= depth_next;
            halt_reg   <= halt_next;
            rd_ptr_reg <= rd_ptr_reg + PtrW'(pop);
            cnt_reg    <= cnt_after + CntW'(n_res);
        end
    end

    // input payload and queue entries hold no reset
    always_ff @(posedge clk)
    begin
        if (char_chan.valid && char_chan.ready)
        begin
            in_char_reg <= char_chan.char_in;
            in_eoi_reg  <= char_chan.end_of_input;
        end
        for (int i = 0; i < MAX_RES; i++)
        begin
            if (ResW'(i) < n_res)
            begin
                q_reg[wr_ptr + PtrW'(i)] <= res_arr[i];
            end
        end
    end

endmodule
